/* rtl/stbm_pkg.sv */
// Package for the sensor table bind/merge block: beat payload types,
// slot storage word, and controller command/status structs. No dependencies.
`timescale 1ns / 1ps

package stbm_pkg;

  localparam logic [31:0] StaleResetMs = 32'd60000;

  typedef struct packed {
    logic [47:0]        dev_addr;
    logic               temp_valid;
    logic signed [15:0] temp_centi;
    logic               hum_valid;
    logic [9:0]         hum_tenths;
    logic               batt_valid;
    logic [6:0]         batt_pct;
    logic [31:0]        now_ms;
  } in_beat_t;

  typedef struct packed {
    logic               accepted;
    logic [2:0]         slot_index;
    logic               newly_bound;
    logic               evicted;
    logic               rec_temp_valid;
    logic signed [15:0] rec_temp_centi;
    logic               rec_hum_valid;
    logic [9:0]         rec_hum_tenths;
    logic               rec_batt_valid;
    logic [6:0]         rec_batt_pct;
    logic [3:0]         bound_count;
    logic [3:0]         live_count;
  } out_beat_t;

  // One table entry as held in the slot memory
  typedef struct packed {
    logic [47:0] addr;
    logic [31:0] last_heard;
    logic [15:0] temp;
    logic [9:0]  hum;
    logic [6:0]  batt;
    logic        temp_v;
    logic        hum_v;
    logic        batt_v;
  } slot_t;

  typedef struct packed {
    logic load;
    logic walk;
    logic commit;
  } stbm_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic out_free;
  } stbm_sts_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_COMMIT
  } stbm_state_e;

endpackage

/* rtl/stbm_ctrl.sv */
// Controller for the sensor table: sequences accept, table walk and commit.
// Depends on stbm_pkg for the state enum and command/status structs.
`timescale 1ns / 1ps

module stbm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  stbm_pkg::stbm_sts_t sts_i,
  output stbm_pkg::stbm_cmd_t cmd_o
);
  import stbm_pkg::*;

  stbm_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_WALK;
      end
      ST_WALK: begin
        if (sts_i.walk_done) state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o    = 1'b1;
    cmd_o         = '0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_WALK: begin
        cmd_o.walk = 1'b1;
      end
      ST_COMMIT: begin
        // hold until the result register can take the beat
        cmd_o.commit = sts_i.out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

/* rtl/stbm_dpath.sv */
// Datapath for the sensor table: slot memory, lookup/LRU/live walk,
// merge and result register. Depends on stbm_pkg; driven by stbm_ctrl.
`timescale 1ns / 1ps

module stbm_dpath #(
  parameter int MAX_SLOTS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i,
  input  stbm_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output stbm_pkg::out_beat_t out_data_o,
  input  stbm_pkg::stbm_cmd_t cmd_i,
  output stbm_pkg::stbm_sts_t sts_o
);
  import stbm_pkg::*;

  localparam int IW = $clog2(MAX_SLOTS);
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_SLOTS);

  slot_t mem_q [MAX_SLOTS];

  in_beat_t        in_q;
  logic [31:0]     stale_q;
  logic [CW-1:0]   bound_q, bound_d;
  logic [CW-1:0]   rd_q;
  logic            pend_q;
  logic [IW-1:0]   cmp_idx_q;
  slot_t           rdata_q;
  logic            found_q;
  logic [IW-1:0]   match_idx_q;
  slot_t           match_q;
  logic            match_live_q;
  logic [31:0]     min_t_q;
  logic [IW-1:0]   min_idx_q;
  logic            min_live_q;
  logic [CW-1:0]   live_cnt_q;
  out_beat_t       out_q, out_d;
  logic            out_valid_q;

  logic            issue;
  logic [31:0]     age;
  logic            cmp_live;
  logic            cmp_hit;
  logic            cmp_lower;

  logic            any_rd, full, newb, evict;
  logic [IW-1:0]   idx;
  slot_t           base, merged;
  logic [CW-1:0]   live_n;

  assign issue     = cmd_i.walk && (rd_q < bound_q);
  assign age       = in_q.now_ms - rdata_q.last_heard;
  assign cmp_live  = (rdata_q.last_heard != '0) && (age <= stale_q);
  assign cmp_hit   = pend_q && !found_q && (rdata_q.addr == in_q.dev_addr);
  assign cmp_lower = (cmp_idx_q == '0) || (rdata_q.last_heard < min_t_q);

  assign sts_o.walk_done = (rd_q == bound_q) && !pend_q;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  // Merge and result assembly for the commit cycle
  always_comb begin
    any_rd = in_q.temp_valid || in_q.hum_valid || in_q.batt_valid;
    full   = (bound_q == MaxCnt);
    newb   = any_rd && !found_q;
    evict  = newb && full;
    if (found_q) begin
      idx  = match_idx_q;
      base = match_q;
    end else begin
      idx  = full ? min_idx_q : bound_q[IW-1:0];
      base = '0;
    end
    merged            = base;
    merged.addr       = in_q.dev_addr;
    merged.last_heard = in_q.now_ms;
    if (in_q.temp_valid) begin
      merged.temp   = in_q.temp_centi;
      merged.temp_v = 1'b1;
    end
    if (in_q.hum_valid) begin
      merged.hum   = in_q.hum_tenths;
      merged.hum_v = 1'b1;
    end
    if (in_q.batt_valid) begin
      merged.batt   = in_q.batt_pct;
      merged.batt_v = 1'b1;
    end

    bound_d = bound_q;
    if (newb && !full) bound_d = bound_q + CW'(1);

    // swap the updated slot's old liveness for its new one
    live_n = live_cnt_q;
    if (any_rd && found_q) live_n = live_n - CW'(match_live_q);
    if (evict) live_n = live_n - CW'(min_live_q);
    if (any_rd && (in_q.now_ms != '0)) live_n = live_n + CW'(1);

    out_d = '0;
    if (any_rd) begin
      out_d.accepted       = 1'b1;
      out_d.slot_index     = 3'(idx);
      out_d.newly_bound    = newb;
      out_d.evicted        = evict;
      out_d.rec_temp_valid = merged.temp_v;
      out_d.rec_temp_centi = merged.temp;
      out_d.rec_hum_valid  = merged.hum_v;
      out_d.rec_hum_tenths = merged.hum;
      out_d.rec_batt_valid = merged.batt_v;
      out_d.rec_batt_pct   = merged.batt;
    end
    out_d.bound_count = 4'(bound_d);
    out_d.live_count  = 4'(live_n);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stale_q     <= StaleResetMs;
      bound_q     <= '0;
      rd_q        <= '0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) stale_q <= cfg_wdata_i;
      if (cmd_i.load) begin
        rd_q    <= '0;
        pend_q  <= 1'b0;
        found_q <= 1'b0;
      end else begin
        pend_q <= issue;
        if (issue) rd_q <= rd_q + CW'(1);
        if (cmp_hit) found_q <= 1'b1;
      end
      if (cmd_i.commit) begin
        bound_q     <= bound_d;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q       <= in_data_i;
      live_cnt_q <= '0;
    end
    if (issue) begin
      rdata_q   <= mem_q[rd_q[IW-1:0]];
      cmp_idx_q <= rd_q[IW-1:0];
    end
    if (pend_q && !cmd_i.load) begin
      if (cmp_live) live_cnt_q <= live_cnt_q + CW'(1);
      if (cmp_hit) begin
        match_idx_q  <= cmp_idx_q;
        match_q      <= rdata_q;
        match_live_q <= cmp_live;
      end
      if (cmp_lower) begin
        min_t_q    <= rdata_q.last_heard;
        min_idx_q  <= cmp_idx_q;
        min_live_q <= cmp_live;
      end
    end
    if (cmd_i.commit) begin
      out_q <= out_d;
      if (any_rd) mem_q[idx] <= merged;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_bound_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bound_q <= MaxCnt)
    else $error("bound count above table depth");

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (!out_valid_q || !out_stall_i))
    else $error("commit while result register still occupied");

  a_commit_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> out_valid_q)
    else $error("commit did not raise result valid");

  a_live_le_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.live_count <= out_q.bound_count))
    else $error("live count exceeds bound count");
`endif

endmodule

/* rtl/sensor_table_bind_merge_core.sv */
// Top level of the sensor table bind/merge block: joins controller and datapath.
// Depends on stbm_pkg, stbm_ctrl and stbm_dpath.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid_i/in_stall_o | in_data_i  (in_beat_t)
//   out     | output    | out_valid_o/out_stall_i | out_data_o (out_beat_t)
//   cfg     | input     | cfg_we_i              | cfg_wdata_i (stale_after_ms)
//
// Beats are taken one at a time: a new beat is accepted only once the last one has
// walked its B bound slots and committed. The walk reads the single-port slot
// memory one entry per cycle.
// The result sits in an output register, so the next beat is accepted while
// it waits; commit of the following beat waits while out_stall_i holds it.
// Reset clears the bound count and sets stale_after_ms to 60000; slot
// memory needs no clearing, only bound slots are read.
`timescale 1ns / 1ps

module sensor_table_bind_merge_core #(
  parameter int MAX_SLOTS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  stbm_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output stbm_pkg::out_beat_t out_data_o
);
  import stbm_pkg::*;

  stbm_cmd_t cmd;
  stbm_sts_t sts;

  stbm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  stbm_dpath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

/* verif/tb_sensor_table_bind_merge_core.sv */
// Testbench for sensor_table_bind_merge_core: drives sensor report beats, predicts each
// result beat from its own copy of the slot table, and checks the results in order.
// Depends on stbm_pkg and the RTL of sensor_table_bind_merge_core.
`timescale 1ns / 1ps

module tb_sensor_table_bind_merge_core;
  import stbm_pkg::*;

  localparam int NumSlots      = 8;
  localparam int HoldCycles    = 400;
  localparam int WatchdogLimit = 4000;

  logic        clk       = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_beat_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_beat_t   out_data;

  sensor_table_bind_merge_core #(
    .MAX_SLOTS(NumSlots)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the slot table and the stale limit
  logic [47:0] tbl_addr  [NumSlots];
  logic [31:0] tbl_heard [NumSlots];
  logic [15:0] tbl_temp  [NumSlots];
  logic [9:0]  tbl_hum   [NumSlots];
  logic [6:0]  tbl_batt  [NumSlots];
  logic        tbl_tv    [NumSlots];
  logic        tbl_hv    [NumSlots];
  logic        tbl_bv    [NumSlots];
  int          tbl_bound = 0;
  logic [31:0] stale_ms  = StaleResetMs;

  out_beat_t   merged_q[$];

  // Stimulus state
  logic [47:0] addr_pool [16];
  int          pool_span   = 8;
  logic [31:0] clock_ms    = 32'd100000;
  int          no_gap_left = 0;
  bit          hold_req    = 1'b0;

  int mismatches   = 0;
  int n_reports    = 0;
  int n_ignored    = 0;
  int n_results    = 0;
  int n_evictions  = 0;
  int quiet_cycles = 0;

  function automatic out_beat_t merge_report(in_beat_t r);
    out_beat_t   res;
    int          slot;
    int          i;
    int          live;
    bit          hit;
    logic [31:0] age;
    res  = '0;
    slot = 0;
    hit  = 1'b0;
    live = 0;
    if (r.temp_valid || r.hum_valid || r.batt_valid) begin
      i = 0;
      while (!hit && i < tbl_bound) begin
        if (tbl_addr[i] == r.dev_addr) begin
          hit  = 1'b1;
          slot = i;
        end else begin
          i++;
        end
      end
      if (!hit) begin
        res.newly_bound = 1'b1;
        if (tbl_bound < NumSlots) begin
          slot = tbl_bound;
          tbl_bound++;
        end else begin
          // reuse the least recently heard slot, lowest index on a tie
          res.evicted = 1'b1;
          n_evictions++;
          for (i = 1; i < NumSlots; i++) begin
            if (tbl_heard[i] < tbl_heard[slot]) slot = i;
          end
        end
        tbl_addr[slot] = r.dev_addr;
        tbl_tv[slot]   = 1'b0;
        tbl_hv[slot]   = 1'b0;
        tbl_bv[slot]   = 1'b0;
        tbl_temp[slot] = '0;
        tbl_hum[slot]  = '0;
        tbl_batt[slot] = '0;
      end
      if (r.temp_valid) begin
        tbl_temp[slot] = r.temp_centi;
        tbl_tv[slot]   = 1'b1;
      end
      if (r.hum_valid) begin
        tbl_hum[slot] = r.hum_tenths;
        tbl_hv[slot]  = 1'b1;
      end
      if (r.batt_valid) begin
        tbl_batt[slot] = r.batt_pct;
        tbl_bv[slot]   = 1'b1;
      end
      tbl_heard[slot] = r.now_ms;

      res.accepted       = 1'b1;
      res.slot_index     = 3'(slot);
      res.rec_temp_valid = tbl_tv[slot];
      res.rec_temp_centi = tbl_temp[slot];
      res.rec_hum_valid  = tbl_hv[slot];
      res.rec_hum_tenths = tbl_hum[slot];
      res.rec_batt_valid = tbl_bv[slot];
      res.rec_batt_pct   = tbl_batt[slot];
    end
    for (i = 0; i < tbl_bound; i++) begin
      age = r.now_ms - tbl_heard[i];
      if (tbl_heard[i] != 32'd0 && age <= stale_ms) live++;
    end
    res.bound_count = 4'(tbl_bound);
    res.live_count  = 4'(live);
    return res;
  endfunction

  function automatic in_beat_t make_report(logic [47:0] addr, logic tv, logic [15:0] tc,
                                           logic hv, logic [9:0] hu, logic bv,
                                           logic [6:0] bp, logic [31:0] now);
    in_beat_t r;
    r.dev_addr   = addr;
    r.temp_valid = tv;
    r.temp_centi = tc;
    r.hum_valid  = hv;
    r.hum_tenths = hu;
    r.batt_valid = bv;
    r.batt_pct   = bp;
    r.now_ms     = now;
    return r;
  endfunction

  function automatic logic [47:0] rand_addr();
    return {16'($urandom), $urandom};
  endfunction

  function automatic in_beat_t random_report();
    in_beat_t    r;
    int          pick;
    logic [47:0] addr;
    pick = $urandom_range(0, 99);
    if (pick < 30) clock_ms += $urandom_range(0, 50);
    else if (pick < 70) clock_ms += $urandom_range(0, 3000);
    else if (pick < 85 && tbl_bound > 0)
      // land next to the stale boundary of some bound slot
      clock_ms = tbl_heard[$urandom_range(0, tbl_bound - 1)] + stale_ms - 1
                 + $urandom_range(0, 2);
    else if (pick < 93) clock_ms = $urandom;
    else if (pick < 96) clock_ms = 32'd0;
    else clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 100);

    if ($urandom_range(0, 99) < 3) addr_pool[$urandom_range(2, 15)] = rand_addr();
    if ($urandom_range(0, 99) < 85) addr = addr_pool[$urandom_range(0, pool_span - 1)];
    else addr = rand_addr();

    r = make_report(addr,
                    $urandom_range(0, 99) < 60, 16'($urandom),
                    $urandom_range(0, 99) < 60,
                    ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 1000)),
                    $urandom_range(0, 99) < 60,
                    ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, 100)),
                    clock_ms);
    if ($urandom_range(0, 99) < 8) begin
      r.temp_valid = 1'b0;
      r.hum_valid  = 1'b0;
      r.batt_valid = 1'b0;
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (no_gap_left > 0) begin
      no_gap_left--;
      return 0;
    end
    if (pick < 3) begin
      no_gap_left = $urandom_range(30, 60);
      return 0;
    end
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Offer one beat from a falling edge; return at the falling edge after acceptance
  task automatic send_report(in_beat_t rpt, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= rpt;
    do @(posedge clk); while (in_stall);
    merged_q.push_back(merge_report(rpt));
    if (rpt.temp_valid || rpt.hum_valid || rpt.batt_valid) n_reports++;
    else n_ignored++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (merged_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_stale(logic [31:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
    stale_ms  = value;
  endtask

  // Send random beats until n of them carry a reading
  task automatic run_random(int n);
    int       sent;
    in_beat_t rpt;
    sent = 0;
    while (sent < n) begin
      rpt = random_report();
      if (rpt.temp_valid || rpt.hum_valid || rpt.batt_valid) sent++;
      send_report(rpt, pick_gap());
    end
  endtask

  task automatic test_directed_bind_merge();
    logic [47:0] a;
    a = 48'h0012_3456_789A;
    send_report(make_report(a, 1'b0, 16'h7FFF, 1'b0, 10'd0, 1'b0, 7'd0, 32'd100), pick_gap());
    send_report(make_report(a, 1'b1, -16'sd1234, 1'b0, 10'd0, 1'b0, 7'd0, 32'd1000),
                pick_gap());
    send_report(make_report(a, 1'b0, 16'd0, 1'b1, 10'd555, 1'b0, 7'd0, 32'd1500), pick_gap());
    send_report(make_report(a, 1'b0, 16'd0, 1'b0, 10'd0, 1'b1, 7'd127, 32'd2000), pick_gap());
    send_report(make_report(48'hFFFF_FFFF_FFFF, 1'b1, 16'h8000, 1'b1, 10'd1023, 1'b1, 7'd0,
                            32'd2000), pick_gap());
    // zero last-heard time: bound but never live
    send_report(make_report(48'h0, 1'b1, 16'h7FFF, 1'b0, 10'd0, 1'b1, 7'd100, 32'd0),
                pick_gap());
    // second slot sits exactly on the default stale limit, then one past it
    send_report(make_report(a, 1'b1, 16'd0, 1'b0, 10'd0, 1'b0, 7'd0, 32'd62000), pick_gap());
    send_report(make_report(a, 1'b0, 16'd0, 1'b0, 10'd0, 1'b0, 7'd0, 32'd62001), pick_gap());
  endtask

  task automatic test_directed_evict_age();
    int k;
    for (k = 0; k < 5; k++)
      send_report(make_report(48'h5000 + k, 1'b1, 16'(k * 100), 1'b1, 10'(k), 1'b0, 7'd0,
                              32'd62002), pick_gap());
    // full table: evict the zero-time slot, then the two oldest
    send_report(make_report(48'hA1, 1'b0, 16'd0, 1'b1, 10'd1000, 1'b1, 7'd50, 32'd62010),
                pick_gap());
    send_report(make_report(48'hA2, 1'b1, 16'd5, 1'b0, 10'd0, 1'b0, 7'd0, 32'd62011),
                pick_gap());
    send_report(make_report(48'hA3, 1'b0, 16'd0, 1'b0, 10'd0, 1'b1, 7'd1, 32'd62012),
                pick_gap());
    // evict on a tie just before the timer wraps, then hit just after it
    send_report(make_report(48'hA4, 1'b1, 16'd100, 1'b1, 10'd200, 1'b1, 7'd30,
                            32'hFFFF_FFF0), pick_gap());
    send_report(make_report(48'hA3, 1'b1, 16'hFFFF, 1'b0, 10'd0, 1'b0, 7'd0, 32'h0000_0010),
                pick_gap());
  endtask

  task automatic test_stale_sweep();
    write_stale(32'd0);
    pool_span = 6;
    run_random(120);
    write_stale(32'hFFFF_FFFF);
    pool_span = 16;
    run_random(120);
    write_stale(32'd1);
    pool_span = 10;
    run_random(120);
    write_stale(32'd1000);
    run_random(120);
    write_stale(StaleResetMs);
    pool_span = 9;
    run_random(120);
  endtask

  task automatic test_output_backpressure();
    int k;
    hold_req = 1'b1;
    for (k = 0; k < 24; k++) send_report(random_report(), 0);
  endtask

  task automatic test_random_traffic();
    write_stale($urandom_range(1, 100000));
    pool_span = 12;
    run_random(300);
    write_stale($urandom);
    pool_span = 16;
    run_random(250);
  endtask

  initial begin
    int k;
    addr_pool[0] = 48'h0;
    addr_pool[1] = 48'hFFFF_FFFF_FFFF;
    for (k = 2; k < 16; k++) addr_pool[k] = rand_addr();
    repeat (12) @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    test_directed_bind_merge();
    test_directed_evict_age();
    test_stale_sweep();
    test_output_backpressure();
    test_random_traffic();

    drain_results();
    repeat (16) @(negedge clk);
    $display("covered %0d reports with readings, %0d without, %0d evictions,",
             n_reports, n_ignored, n_evictions);
    $display("%0d result beats checked over eight stale limit settings and one long output hold",
             n_results);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Receiver pacing; a hold request blocks the output for a long stretch
  int stall_left = 0;
  int hold_left  = 0;
  always @(negedge clk) begin : rx_pace
    int pick;
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (stall_left > 0) begin
      stall_left--;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        out_stall <= 1'b0;
        stall_left = $urandom_range(0, 7);
      end else if (pick < 62) begin
        out_stall <= 1'b0;
        stall_left = $urandom_range(30, 80);
      end else if (pick < 90) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(0, 2);
      end else if (pick < 97) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(3, 14);
      end else begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(20, 50);
      end
    end
  end

  function automatic void check_field(string name, logic [47:0] exp_v, logic [47:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    out_beat_t want;
    if (rst_ni && out_valid && !out_stall) begin
      n_results++;
      if (merged_q.size() == 0) begin
        $error("result beat with nothing expected");
        mismatches++;
      end else begin
        want = merged_q.pop_front();
        check_field("accepted", 48'(want.accepted), 48'(out_data.accepted));
        check_field("slot_index", 48'(want.slot_index), 48'(out_data.slot_index));
        check_field("newly_bound", 48'(want.newly_bound), 48'(out_data.newly_bound));
        check_field("evicted", 48'(want.evicted), 48'(out_data.evicted));
        check_field("rec_temp_valid", 48'(want.rec_temp_valid),
                    48'(out_data.rec_temp_valid));
        check_field("rec_temp_centi", 48'($unsigned(want.rec_temp_centi)),
                    48'($unsigned(out_data.rec_temp_centi)));
        check_field("rec_hum_valid", 48'(want.rec_hum_valid), 48'(out_data.rec_hum_valid));
        check_field("rec_hum_tenths", 48'(want.rec_hum_tenths),
                    48'(out_data.rec_hum_tenths));
        check_field("rec_batt_valid", 48'(want.rec_batt_valid),
                    48'(out_data.rec_batt_valid));
        check_field("rec_batt_pct", 48'(want.rec_batt_pct), 48'(out_data.rec_batt_pct));
        check_field("bound_count", 48'(want.bound_count), 48'(out_data.bound_count));
        check_field("live_count", 48'(want.live_count), 48'(out_data.live_count));
      end
    end
  end

  // End the run if no beat moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $error("watchdog: no beat for %0d cycles, %0d results pending",
               quiet_cycles, merged_q.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

endmodule
